// ===== rtl/rgba_box_downscaler_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RGBA_BOX_DOWNSCALER_DEFINES_SVH
`define RGBA_BOX_DOWNSCALER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define RBD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rbd check failed");

// Property that must hold in the cycle after its trigger.
`define RBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rbd check failed");

`endif

// ===== rtl/rbd_pkg.sv =====
package rbd_pkg;

  localparam int MAX_SOURCE_DIM_C = 4096;
  localparam int MAX_TARGET_DIM_C = 1024;

  localparam int DIM_W      = 13;
  localparam int TGT_CFG_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 25;
  localparam int POS_OUT_W  = 10;
  localparam int IN_DATA_W  = NUM_CH * CH_W;
  localparam int OUT_DATA_W = 56;
  localparam int PAD_W      = OUT_DATA_W - NUM_CH * CH_W - 2 * POS_OUT_W;

  localparam int STEP_W     = 4;
  localparam int AVG_STEPS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 2'd3;

  typedef struct packed {
    logic       init_start;
    logic       init_step;
    logic       restart;
    logic       take;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] pair;
    logic       div_load;
    logic       div_step;
    logic       out_load;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic [3:0] pair_ok;
    logic       emit;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/rbd_axis.sv =====
// Tracks one axis: source position, the box that holds it, and the box bounds.
// Bounds advance by n/d per box, so n/d is found once by a serial divider.
module rbd_axis import rbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIM_W-1:0] n_i,
  input  logic [DIM_W-1:0] d_i,
  input  logic             init_start_i,
  input  logic             init_step_i,
  input  logic             restart_i,
  input  logic             advance_i,
  output logic [DIM_W-1:0] box_o,
  output logic             first_o,
  output logic             share_o,
  output logic             last_o,
  output logic             wrap_o
);

  logic [DIM_W-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [DIM_W-1:0] pos_q, pos_d, box_q, box_d, start_q, start_d, nq_q, nq_d, nr_q, nr_d;
  logic [DIM_W:0]   shifted, end_w, pos_inc, nr_sum;
  logic             ge;

  assign shifted = {rem_q, quo_q[DIM_W-1]};
  assign ge      = shifted >= {1'b0, d_i};
  // End of the current box is the ceiling of (box+1)*n/d.
  assign end_w   = {1'b0, nq_q} + {{DIM_W{1'b0}}, (nr_q != '0)};
  assign pos_inc = {1'b0, pos_q} + 1'b1;
  assign nr_sum  = {1'b0, nr_q} + {1'b0, rem_q};

  assign box_o   = box_q;
  assign first_o = pos_q == start_q;
  assign share_o = (({1'b0, box_q} + 1'b1) < {1'b0, d_i}) && (nq_q == pos_q);
  assign last_o  = pos_inc == end_w;
  assign wrap_o  = pos_inc == {1'b0, n_i};

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    pos_d   = pos_q;
    box_d   = box_q;
    start_d = start_q;
    nq_d    = nq_q;
    nr_d    = nr_q;
    if (init_start_i) begin
      rem_d = '0;
      quo_d = n_i;
    end else if (init_step_i) begin
      rem_d = ge ? DIM_W'(shifted - {1'b0, d_i}) : shifted[DIM_W-1:0];
      quo_d = {quo_q[DIM_W-2:0], ge};
    end
    if (restart_i || (advance_i && wrap_o)) begin
      pos_d   = '0;
      box_d   = '0;
      start_d = '0;
      nq_d    = quo_q;
      nr_d    = rem_q;
    end else if (advance_i) begin
      pos_d = pos_inc[DIM_W-1:0];
      if (pos_inc == end_w) begin
        box_d   = box_q + 1'b1;
        start_d = nq_q;
        if (nr_sum >= {1'b0, d_i}) begin
          nr_d = DIM_W'(nr_sum - {1'b0, d_i});
          nq_d = nq_q + quo_q + 1'b1;
        end else begin
          nr_d = nr_sum[DIM_W-1:0];
          nq_d = nq_q + quo_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      quo_q   <= '0;
      pos_q   <= '0;
      box_q   <= '0;
      start_q <= '0;
      nq_q    <= '0;
      nr_q    <= '0;
    end else begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      pos_q   <= pos_d;
      box_q   <= box_d;
      start_q <= start_d;
      nq_q    <= nq_d;
      nr_q    <= nr_d;
    end
  end

endmodule

// ===== rtl/rbd_ctrl.sv =====
module rbd_ctrl import rbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_ready_o
);

  localparam logic [3:0] S_START   = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_RESTART = 4'd2;
  localparam logic [3:0] S_IDLE    = 4'd3;
  localparam logic [3:0] S_RD      = 4'd4;
  localparam logic [3:0] S_WR      = 4'd5;
  localparam logic [3:0] S_ADV     = 4'd6;
  localparam logic [3:0] S_AVG     = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        pair_q, pair_d;
  logic              more;
  logic [1:0]        next_pair;

  // Pick the next box touched by this word; the first box always exists.
  always_comb begin
    more      = 1'b0;
    next_pair = pair_q;
    case (pair_q)
      2'd0: begin
        if (status_i.pair_ok[1]) begin
          more      = 1'b1;
          next_pair = 2'd1;
        end else if (status_i.pair_ok[2]) begin
          more      = 1'b1;
          next_pair = 2'd2;
        end
      end
      2'd1: begin
        more      = status_i.pair_ok[2];
        next_pair = 2'd2;
      end
      2'd2: begin
        more      = status_i.pair_ok[3];
        next_pair = 2'd3;
      end
      default: more = 1'b0;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.pair = pair_q;
    in_ready_o = 1'b0;
    state_d    = state_q;
    step_d     = step_q;
    pair_d     = pair_q;
    case (state_q)
      S_START: begin
        cmd_o.init_start = 1'b1;
        step_d           = '0;
        state_d          = S_INIT;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == STEP_W'(DIM_W - 1)) state_d = S_RESTART;
      end
      S_RESTART: begin
        cmd_o.restart = 1'b1;
        state_d       = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          pair_d     = 2'd0;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_WR;
      end
      S_WR: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.div_load = pair_q == 2'd0;
        if (more) begin
          pair_d  = next_pair;
          state_d = S_RD;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        step_d        = '0;
        state_d       = status_i.emit ? S_AVG : S_IDLE;
      end
      S_AVG: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(AVG_STEPS - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_START;
    endcase
    if (cfg_we_i) state_d = S_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_START;
      step_q  <= '0;
      pair_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pair_q  <= pair_d;
    end
  end

endmodule

// ===== rtl/rbd_datapath.sv =====
module rbd_datapath import rbd_pkg::*; #(
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_C,
  parameter int MAX_TARGET_DIM = MAX_TARGET_DIM_C
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int TIDX_W  = (MAX_TARGET_DIM > 1) ? $clog2(MAX_TARGET_DIM) : 1;
  localparam int ADDR_W  = TIDX_W + 1;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int ENTRY_W = NUM_CH * SUM_W + CNT_W;
  localparam int DV_W    = CNT_W + AVG_STEPS - 1;

  logic [DIM_W-1:0]     src_w_q, src_h_q;
  logic [TGT_CFG_W-1:0] tgt_w_q, tgt_h_q;
  logic [DIM_W-1:0]     w_eff, h_eff, dw_eff, dh_eff, dw_c, dh_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(1);
      src_h_q <= DIM_W'(1);
      tgt_w_q <= TGT_CFG_W'(1);
      tgt_h_q <= TGT_CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q <= cfg_wdata_i;
        REG_SRC_HEIGHT: src_h_q <= cfg_wdata_i;
        REG_TGT_WIDTH:  tgt_w_q <= cfg_wdata_i[TGT_CFG_W-1:0];
        REG_TGT_HEIGHT: tgt_h_q <= cfg_wdata_i[TGT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero means one, then clamp to the limits, then the target to the source.
  always_comb begin
    w_eff = (src_w_q == '0) ? DIM_W'(1) :
            (src_w_q > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : src_w_q;
    h_eff = (src_h_q == '0) ? DIM_W'(1) :
            (src_h_q > DIM_W'(MAX_SOURCE_DIM)) ? DIM_W'(MAX_SOURCE_DIM) : src_h_q;
    dw_c  = (tgt_w_q == '0) ? DIM_W'(1) :
            (DIM_W'(tgt_w_q) > DIM_W'(MAX_TARGET_DIM)) ? DIM_W'(MAX_TARGET_DIM) :
            DIM_W'(tgt_w_q);
    dh_c  = (tgt_h_q == '0) ? DIM_W'(1) :
            (DIM_W'(tgt_h_q) > DIM_W'(MAX_TARGET_DIM)) ? DIM_W'(MAX_TARGET_DIM) :
            DIM_W'(tgt_h_q);
    dw_eff = (dw_c > w_eff) ? w_eff : dw_c;
    dh_eff = (dh_c > h_eff) ? h_eff : dh_c;
  end

  logic [DIM_W-1:0] col_box, row_box;
  logic             col_first, col_share, col_last, col_wrap;
  logic             row_first, row_share, row_last, row_wrap;

  rbd_axis u_col (
    .clk_i, .rst_ni,
    .n_i(w_eff), .d_i(dw_eff),
    .init_start_i(cmd_i.init_start), .init_step_i(cmd_i.init_step),
    .restart_i(cmd_i.restart), .advance_i(cmd_i.advance),
    .box_o(col_box), .first_o(col_first), .share_o(col_share),
    .last_o(col_last), .wrap_o(col_wrap)
  );

  rbd_axis u_row (
    .clk_i, .rst_ni,
    .n_i(h_eff), .d_i(dh_eff),
    .init_start_i(cmd_i.init_start), .init_step_i(cmd_i.init_step),
    .restart_i(cmd_i.restart), .advance_i(cmd_i.advance && col_wrap),
    .box_o(row_box), .first_o(row_first), .share_o(row_share),
    .last_o(row_last), .wrap_o(row_wrap)
  );

  logic [IN_DATA_W-1:0] px_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) px_q <= in_data_i;
  end

  // A word touches up to two rows and two columns of boxes.
  logic [DIM_W-1:0]  pr, pc;
  logic [ADDR_W-1:0] addr;
  logic              first;
  assign pr    = row_box + DIM_W'(cmd_i.pair[1]);
  assign pc    = col_box + DIM_W'(cmd_i.pair[0]);
  assign addr  = {pr[0], pc[TIDX_W-1:0]};
  assign first = (cmd_i.pair[1] | row_first) & (cmd_i.pair[0] | col_first);

  assign status_o.pair_ok = {col_share & row_share, row_share, col_share, 1'b1};

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q, wr_entry;
  logic [SUM_W-1:0]   new_sum [NUM_CH];
  logic [CNT_W-1:0]   new_cnt, old_cnt;

  always_comb begin
    old_cnt = rd_q[NUM_CH*SUM_W +: CNT_W];
    new_cnt = first ? CNT_W'(1) : old_cnt + 1'b1;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      new_sum[ch] = first ? SUM_W'(px_q[ch*CH_W +: CH_W])
                          : rd_q[ch*SUM_W +: SUM_W] + SUM_W'(px_q[ch*CH_W +: CH_W]);
    end
    wr_entry = {new_cnt, new_sum[3], new_sum[2], new_sum[1], new_sum[0]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) mem[addr] <= wr_entry;
    if (cmd_i.mem_rd) rd_q <= mem[addr];
  end

  // Restoring divide: the average never exceeds 255, so eight steps suffice.
  logic                 emit_q;
  logic [SUM_W-1:0]     rem_q [NUM_CH];
  logic [CH_W-1:0]      quo_q [NUM_CH];
  logic [DV_W-1:0]      dv_q;
  logic [POS_OUT_W-1:0] emit_col_q, emit_row_q;
  logic                 emit_fd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_q <= 1'b0;
    else if (cmd_i.div_load) emit_q <= row_last & col_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rem_q[ch] <= new_sum[ch];
        quo_q[ch] <= '0;
      end
      dv_q       <= {new_cnt, {(AVG_STEPS-1){1'b0}}};
      emit_col_q <= col_box[POS_OUT_W-1:0];
      emit_row_q <= row_box[POS_OUT_W-1:0];
      emit_fd_q  <= (row_box == dh_eff - 1'b1) && (col_box == dw_eff - 1'b1);
    end else if (cmd_i.div_step) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (rem_q[ch] >= dv_q) begin
          rem_q[ch] <= rem_q[ch] - dv_q;
          quo_q[ch] <= {quo_q[ch][CH_W-2:0], 1'b1};
        end else begin
          quo_q[ch] <= {quo_q[ch][CH_W-2:0], 1'b0};
        end
      end
      dv_q <= dv_q >> 1;
    end
  end

  assign status_o.emit     = emit_q;
  assign status_o.out_free = !out_valid_o || out_ready_i;

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {{PAD_W{1'b0}}, emit_row_q, emit_col_q,
                     quo_q[3], quo_q[2], quo_q[1], quo_q[0]};
      out_last_q <= emit_fd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // The row tracker wraps by itself at the end of a frame.
  logic unused_wrap;
  assign unused_wrap = row_wrap;

endmodule

// ===== rtl/rgba_box_downscaler.sv =====
// Box-filter RGBA downscaler.
// Source pixels enter on the s_axis channel in raster order, one word per pixel
// with red in the lowest byte. The block tracks the source position itself.
// Averaged destination pixels leave on m_axis; tlast marks the last one of a
// frame. Sizes are set through the write port; each write restarts the frame.
// Each accepted word is taken, then each box that it feeds (one to four boxes)
// gets a read then a write of the single-port accumulator memory, and then
// the position steps. A word that completes a box adds eight steps of the
// shared averaging divider and a load of the output register. The pixel is
// shown in the cycle after that load.
// After reset and after every configuration write the block divides the
// sizes with a serial divider, with s_axis_tready low.
// A result waiting in the output register does not hold up the next input;
// only a second result waits until the receiver takes the first.
module rgba_box_downscaler import rbd_pkg::*; #(
  parameter int MAX_SOURCE_DIM = MAX_SOURCE_DIM_C,
  parameter int MAX_TARGET_DIM = MAX_TARGET_DIM_C
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, out_column, out_row, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast    // frame_done
);

  cmd_t    cmd;
  status_t status;

  rbd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .cfg_we_i,
    .in_valid_i(s_axis_tvalid),
    .status_i(status),
    .cmd_o(cmd),
    .in_ready_o(s_axis_tready)
  );

  rbd_datapath #(
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM),
    .MAX_TARGET_DIM(MAX_TARGET_DIM)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_data_i(s_axis_tdata),
    .cmd_i(cmd),
    .status_o(status),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata),
    .out_last_o(m_axis_tlast)
  );

endmodule

// ===== rtl/rbd_checker.sv =====
`include "rgba_box_downscaler_defines.svh"

module rbd_checker import rbd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Every word needs at least one memory pass, so the input closes right after.
  `RBD_ASSERT_NEXT(a_busy_after_word, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A size change always triggers the size division before new input.
  `RBD_ASSERT_NEXT(a_init_after_cfg, clk_i, rst_ni, cfg_we_i, !s_axis_tready)

  `RBD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind rgba_box_downscaler rbd_checker u_rbd_checker (.*);
